FILE: hdl/elrc_pkg.sv
// Package for the expiring LRU result cache: table size, widths, command codes.
// No dependencies; the interfaces, the cache unit and the checker import it (elrc_ram does not).
`timescale 1ns / 1ps

package elrc_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 48;
  localparam int unsigned AGE_W = 33;
  localparam int unsigned ENTRY_W = KEY_W + 3 * VAL_W;

  typedef enum logic [1:0] {
    CMD_LOOKUP    = 2'd0,
    CMD_STORE     = 2'd1,
    CMD_INVAL_KEY = 2'd2,
    CMD_INVAL_ALL = 2'd3
  } cmd_e;

  // One table entry as it lies in the data memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] bytes;
    logic [VAL_W-1:0] time_ms;
    logic [VAL_W-1:0] stamp;
  } entry_t;

endpackage

FILE: hdl/elrc_if.sv
// Request and result channel interfaces of the expiring LRU result cache.
// Depends on elrc_pkg for the field widths.
`timescale 1ns / 1ps

interface elrc_req_if import elrc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [KEY_W-1:0]        dir_key;
  logic [VAL_W-1:0]        now_ms;
  logic signed [AGE_W-1:0] max_age_ms;
  logic signed [VAL_W-1:0] dir_mtime_ms;
  logic [VAL_W-1:0]        byte_total;
  logic                    store_ok;

  modport source (output valid, command, dir_key, now_ms, max_age_ms, dir_mtime_ms,
                  byte_total, store_ok, input ready);
  modport sink (input valid, command, dir_key, now_ms, max_age_ms, dir_mtime_ms,
                byte_total, store_ok, output ready);
endinterface

interface elrc_rsp_if import elrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [VAL_W-1:0] byte_total_out;
  logic             size_ready;

  modport source (output valid, hit, byte_total_out, size_ready, input ready);
  modport sink (input valid, hit, byte_total_out, size_ready, output ready);
endinterface

FILE: hdl/elrc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Standalone; used for the entry data and the recency ranks.
`timescale 1ns / 1ps

module elrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hdl/expiring_lru_result_cache_unit.sv
// Expiring LRU result cache: key to byte-total table with age and stamp checks.
// A lookup is one sweep; store/invalidate of a present key or a store into a full table adds
// a second sweep (FIX); invalidate-all and dropped stores answer straight from IDLE, no sweep.
// One request at a time; the cost is the linear sweep over the entry memories.
// Reset (async, active low) clears valid bits, entry count and the result valid flag.
`timescale 1ns / 1ps

module expiring_lru_result_cache_unit import elrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  elrc_req_if.sink    req_i,
  elrc_rsp_if.source  rsp_o
);

  // Sequencer states. SCAN sweeps the table to find the key, a free slot and the
  // oldest entry. FIX sweeps again to close the gap left in the ranks. WRITE stores
  // the entry.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FIX   = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  logic [1:0] state_q, state_d;

  // Captured request.
  logic [1:0]              cmd_q;
  logic [KEY_W-1:0]        key_q;
  logic [VAL_W-1:0]        now_q;
  logic signed [AGE_W-1:0] age_lim_q;
  logic [VAL_W-1:0]        mt_q;
  logic [VAL_W-1:0]        bytes_q;

  // Table state held in flip-flops.
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]    count_q, count_d;

  // Sweep pipeline: issue counter and the index whose data arrives this cycle.
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0] chk_idx_q, chk_idx_d;

  // Scan findings.
  logic             found_q, found_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [IDX_W-1:0] rank_hit_q, rank_hit_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_q, free_d;
  logic             old_found_q, old_found_d;
  logic [IDX_W-1:0] old_q, old_d;
  logic             lhit_q, lhit_d;
  logic [VAL_W-1:0] lbytes_q, lbytes_d;

  // Write-back target.
  logic [IDX_W-1:0] tgt_q, tgt_d;
  logic [IDX_W-1:0] new_rank_q, new_rank_d;
  logic [IDX_W-1:0] gone_q, gone_d;

  // Result register.
  logic             out_vld_q, out_vld_d;
  logic             out_hit_q, out_hit_d;
  logic [VAL_W-1:0] out_bytes_q, out_bytes_d;
  logic             out_size_q, out_size_d;

  // Memory ports.
  logic             dat_we, rnk_we;
  logic [IDX_W-1:0] dat_waddr, rnk_waddr, rd_addr;
  entry_t           dat_wdata, dat_rdata;
  logic [IDX_W-1:0] rnk_wdata, rnk_rdata;

  logic                    accept;
  logic                    sweep_done;
  logic                    ent_vld;
  logic signed [VAL_W:0]   age;
  logic signed [VAL_W:0]   lim;
  logic                    age_ok, stamp_ok;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE) && !out_vld_q;

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.hit            = out_hit_q;
  assign rsp_o.byte_total_out = out_bytes_q;
  assign rsp_o.size_ready     = out_size_q;

  assign rd_addr    = issue_q[IDX_W-1:0];
  assign sweep_done = (issue_q == CNT_W'(CAPACITY)) && !chk_vld_q;
  assign ent_vld    = chk_vld_q && valid_q[chk_idx_q];

  // Age is a signed difference; a stored time later than now gives a negative age.
  assign age      = $signed({1'b0, now_q}) - $signed({1'b0, dat_rdata.time_ms});
  assign lim      = (VAL_W + 1)'(age_lim_q);
  assign age_ok   = age_lim_q[AGE_W-1] || !(age > lim);
  assign stamp_ok = mt_q[VAL_W-1] || (dat_rdata.stamp == mt_q);

  elrc_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_dat_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (dat_waddr),
    .wdata_i (dat_wdata),
    .raddr_i (rd_addr),
    .rdata_o (dat_rdata)
  );

  elrc_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_rnk_ram (
    .clk_i   (clk_i),
    .we_i    (rnk_we),
    .waddr_i (rnk_waddr),
    .wdata_i (rnk_wdata),
    .raddr_i (rd_addr),
    .rdata_o (rnk_rdata)
  );

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    count_d      = count_q;
    issue_d      = issue_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = rd_addr;
    found_d      = found_q;
    slot_d       = slot_q;
    rank_hit_d   = rank_hit_q;
    free_found_d = free_found_q;
    free_d       = free_q;
    old_found_d  = old_found_q;
    old_d        = old_q;
    lhit_d       = lhit_q;
    lbytes_d     = lbytes_q;
    tgt_d        = tgt_q;
    new_rank_d   = new_rank_q;
    gone_d       = gone_q;
    out_vld_d    = out_vld_q && !rsp_o.ready;
    out_hit_d    = out_hit_q;
    out_bytes_d  = out_bytes_q;
    out_size_d   = out_size_q;
    dat_we       = 1'b0;
    dat_waddr    = tgt_q;
    dat_wdata    = '{key: key_q, bytes: bytes_q, time_ms: now_q, stamp: mt_q};
    rnk_we       = 1'b0;
    rnk_waddr    = chk_idx_q;
    rnk_wdata    = rnk_rdata - IDX_W'(1);

    // Read issue side of a sweep, shared by SCAN and FIX.
    if ((state_q == ST_SCAN || state_q == ST_FIX) && issue_q != CNT_W'(CAPACITY)) begin
      issue_d   = issue_q + CNT_W'(1);
      chk_vld_d = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        issue_d      = '0;
        found_d      = 1'b0;
        free_found_d = 1'b0;
        old_found_d  = 1'b0;
        lhit_d       = 1'b0;
        lbytes_d     = '0;
        if (accept) begin
          if (req_i.command == CMD_INVAL_ALL) begin
            valid_d     = '0;
            count_d     = '0;
            out_vld_d   = 1'b1;
            out_hit_d   = 1'b0;
            out_bytes_d = '0;
            out_size_d  = 1'b0;
          end else if (req_i.command == CMD_STORE && !req_i.store_ok) begin
            // A dropped store leaves the table alone.
            out_vld_d   = 1'b1;
            out_hit_d   = 1'b0;
            out_bytes_d = '0;
            out_size_d  = 1'b0;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (ent_vld && dat_rdata.key == key_q && !found_q) begin
          found_d    = 1'b1;
          slot_d     = chk_idx_q;
          rank_hit_d = rnk_rdata;
          lhit_d     = age_ok && stamp_ok;
          lbytes_d   = dat_rdata.bytes;
        end
        if (chk_vld_q && !valid_q[chk_idx_q] && !free_found_q) begin
          free_found_d = 1'b1;
          free_d       = chk_idx_q;
        end
        if (ent_vld && rnk_rdata == '0 && !old_found_q) begin
          old_found_d = 1'b1;
          old_d       = chk_idx_q;
        end
        if (sweep_done) begin
          issue_d     = '0;
          out_hit_d   = 1'b0;
          out_bytes_d = '0;
          out_size_d  = 1'b0;
          priority case (cmd_q)
            CMD_LOOKUP: begin
              state_d     = ST_IDLE;
              out_vld_d   = 1'b1;
              out_hit_d   = found_q && lhit_q;
              out_bytes_d = (found_q && lhit_q) ? lbytes_q : '0;
            end
            CMD_INVAL_KEY: begin
              if (found_q) begin
                valid_d[slot_q] = 1'b0;
                count_d         = count_q - CNT_W'(1);
                gone_d          = rank_hit_q;
                state_d         = ST_FIX;
              end else begin
                state_d   = ST_IDLE;
                out_vld_d = 1'b1;
              end
            end
            default: begin
              // Store with a valid result.
              if (found_q) begin
                tgt_d      = slot_q;
                gone_d     = rank_hit_q;
                new_rank_d = IDX_W'(count_q - CNT_W'(1));
                state_d    = ST_FIX;
              end else if (count_q < CNT_W'(CAPACITY)) begin
                tgt_d      = free_q;
                new_rank_d = IDX_W'(count_q);
                count_d    = count_q + CNT_W'(1);
                state_d    = ST_WRITE;
              end else begin
                // Full table: evict the oldest entry, then age everyone else.
                tgt_d      = old_found_q ? old_q : '0;
                valid_d[old_found_q ? old_q : '0] = 1'b0;
                gone_d     = '0;
                new_rank_d = IDX_W'(count_q - CNT_W'(1));
                state_d    = ST_FIX;
              end
            end
          endcase
        end
      end

      ST_FIX: begin
        // Every valid entry newer than the removed rank moves down by one.
        rnk_we = ent_vld && (rnk_rdata > gone_q);
        if (sweep_done) begin
          if (cmd_q == CMD_STORE) begin
            state_d = ST_WRITE;
          end else begin
            state_d     = ST_IDLE;
            out_vld_d   = 1'b1;
            out_hit_d   = 1'b0;
            out_bytes_d = '0;
            out_size_d  = 1'b0;
          end
        end
      end

      ST_WRITE: begin
        dat_we         = 1'b1;
        rnk_we         = 1'b1;
        rnk_waddr      = tgt_q;
        rnk_wdata      = new_rank_q;
        valid_d[tgt_q] = 1'b1;
        state_d        = ST_IDLE;
        out_vld_d      = 1'b1;
        out_hit_d      = 1'b0;
        out_bytes_d    = '0;
        out_size_d     = 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      count_q   <= '0;
      issue_q   <= '0;
      chk_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      count_q   <= count_d;
      issue_q   <= issue_d;
      chk_vld_q <= chk_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= req_i.command;
      key_q     <= req_i.dir_key;
      now_q     <= req_i.now_ms;
      age_lim_q <= req_i.max_age_ms;
      mt_q      <= req_i.dir_mtime_ms;
      bytes_q   <= req_i.byte_total;
    end
    chk_idx_q    <= chk_idx_d;
    found_q      <= found_d;
    slot_q       <= slot_d;
    rank_hit_q   <= rank_hit_d;
    free_found_q <= free_found_d;
    free_q       <= free_d;
    old_found_q  <= old_found_d;
    old_q        <= old_d;
    lhit_q       <= lhit_d;
    lbytes_q     <= lbytes_d;
    tgt_q        <= tgt_d;
    new_rank_q   <= new_rank_d;
    gone_q       <= gone_d;
    out_hit_q    <= out_hit_d;
    out_bytes_q  <= out_bytes_d;
    out_size_q   <= out_size_d;
  end

endmodule

FILE: hdl/elrc_checker.sv
// Port-level checker for the expiring LRU result cache, with its bind statement.
// Depends on elrc_pkg and the top level expiring_lru_result_cache_unit.
`timescale 1ns / 1ps

module elrc_checker import elrc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic             rsp_hit_i,
  input logic [VAL_W-1:0] rsp_bytes_i,
  input logic             rsp_size_i
);

  // One request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in progress");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_hit_i)
      && $stable(rsp_bytes_i) && $stable(rsp_size_i))
    else $error("stalled result changed");

  a_hit_xor_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_hit_i && rsp_size_i))
    else $error("result is both a hit and a size notification");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_hit_i |-> rsp_bytes_i == '0)
    else $error("byte total nonzero without a hit");

endmodule

bind expiring_lru_result_cache_unit elrc_checker u_elrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_hit_i   (rsp_o.hit),
  .rsp_bytes_i (rsp_o.byte_total_out),
  .rsp_size_i  (rsp_o.size_ready)
);
